// ===== sv/ecqs_pkg.sv =====
// ---------------------------------------------------------------------------
// ecqs_pkg
// Shared types and constants of the egress class queue scheduler: item
// structs, op and register codes, and the controller/datapath interface.
// ---------------------------------------------------------------------------
package ecqs_pkg;

    // op codes of an input item
    localparam logic OP_ENQUEUE = 1'b0;
    localparam logic OP_DEQUEUE = 1'b1;

    // scheduling modes
    localparam logic MODE_STRICT = 1'b0;
    localparam logic MODE_RR     = 1'b1;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_BYTES  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCHED_MODE = 1'b1;

    localparam logic [31:0] MAX_BYTES_RESET = 32'd1048576000;

    // input item
    typedef struct packed {
        logic        op;
        logic [2:0]  class_index;
        logic [15:0] packet_length;
        logic [7:0]  pause_mask;
    } t_in_item;

    // result item
    typedef struct packed {
        logic        accepted;
        logic        sent;
        logic [2:0]  sent_class;
        logic [15:0] sent_length;
        logic [31:0] total_bytes;
        logic [31:0] class_bytes;
    } t_out_item;

    // controller to datapath
    typedef struct packed {
        logic load_item;  // capture the input item
        logic exec;       // enqueue update, or dequeue pick and head read
        logic finish;     // dequeue byte count update from read data
        logic result;     // result phase: report class bytes of the item
        logic load_out;   // move the result into the output register
    } t_ctrl_cmd;

    // datapath to controller
    typedef struct packed {
        logic is_deq;
        logic found;
        logic out_free;
    } t_dp_status;

endpackage

// ===== sv/ecqs_ctrl.sv =====
// ---------------------------------------------------------------------------
// ecqs_ctrl
// Sequencer of the scheduler: takes one item at a time, walks it through
// execute, head read (if a dequeue sends) and result, then to the output.
// ---------------------------------------------------------------------------
module ecqs_ctrl
    import ecqs_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_dp_status i_status,
    output t_ctrl_cmd  o_cmd
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_EXEC   = 2'd1;
    localparam logic [1:0] S_READ   = 2'd2;
    localparam logic [1:0] S_RESULT = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       take;

    // input is open when idle, or when the result leaves this cycle
    assign o_in_stall = !((r_state == S_IDLE) ||
                          ((r_state == S_RESULT) && i_status.out_free));
    assign take = i_in_valid && !o_in_stall;

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.load_item = take;
        case (r_state)
            S_IDLE: begin
                if (take) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                if (i_status.is_deq && i_status.found) begin
                    n_state = S_READ;
                end else begin
                    n_state = S_RESULT;
                end
            end
            S_READ: begin
                o_cmd.finish = 1'b1;
                n_state      = S_RESULT;
            end
            S_RESULT: begin
                o_cmd.result = 1'b1;
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = take ? S_EXEC : S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== sv/ecqs_dpath.sv =====
// ---------------------------------------------------------------------------
// ecqs_dpath
// Datapath of the scheduler: length memory, per-class pointers, counts and
// byte totals, class selection, configuration registers and output register.
// ---------------------------------------------------------------------------
module ecqs_dpath
    import ecqs_pkg::*;
#(
    parameter int NUM_CLASSES = 8,
    parameter int FIFO_DEPTH  = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_in_item              i_in_item,
    input  logic                  i_out_stall,
    output logic                  o_out_valid,
    output t_out_item             o_out_item,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  t_ctrl_cmd             i_cmd,
    output t_dp_status            o_status
);

    localparam int CLS_W = $clog2(NUM_CLASSES);
    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
    localparam int PAD_W = NUM_CLASSES + 8;

    function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
        ptr_next = (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // configuration
    logic [31:0] r_max_bytes;
    logic        r_sched_mode;

    // queue state
    logic [PTR_W-1:0] r_head  [NUM_CLASSES];
    logic [PTR_W-1:0] r_tail  [NUM_CLASSES];
    logic [CNT_W-1:0] r_count [NUM_CLASSES];
    logic [31:0]      r_bytes [NUM_CLASSES];
    logic [31:0]      r_all;
    logic [CLS_W-1:0] r_rr;

    // length memory
    logic [15:0] mem [NUM_CLASSES][FIFO_DEPTH];
    logic [15:0] r_rd_data;

    // item in flight and its partial result
    t_in_item         r_item;
    logic [CLS_W-1:0] r_wcls;
    logic             r_cls_ok;
    logic             r_acc;
    logic             r_sent;
    logic [2:0]       r_sent_cls;
    logic [15:0]      r_sent_len;

    // output register
    logic      r_out_valid;
    t_out_item r_out_item;

    logic                   is_deq;
    logic [PAD_W-1:0]       pad_mask;
    logic [NUM_CLASSES-1:0] serve;
    logic [2*NUM_CLASSES-1:0] serve_dbl;
    logic [NUM_CLASSES-1:0] serve_rot;
    logic [CLS_W:0]         rot_off;
    logic [CLS_W:0]         rr_sum;
    logic [CLS_W-1:0]       pick_strict;
    logic [CLS_W-1:0]       pick_rr;
    logic [CLS_W-1:0]       pick;
    logic                   found;
    logic                   enq_ok;
    logic [32:0]            sum_bytes;
    logic [CLS_W-1:0]       bytes_idx;
    logic [31:0]            bytes_rd;
    logic                   cls_ok_in;

    assign is_deq    = (r_item.op == OP_DEQUEUE);
    assign cls_ok_in = (32'(i_in_item.class_index) < 32'(NUM_CLASSES));

    // classes that may be served: not paused and not empty
    always_comb begin
        pad_mask = PAD_W'(r_item.pause_mask);
        for (int c = 0; c < NUM_CLASSES; c++) begin
            serve[c] = !pad_mask[c] && (r_count[c] != '0);
        end
    end

    // strict priority: highest served class wins
    always_comb begin
        pick_strict = '0;
        for (int c = 0; c < NUM_CLASSES; c++) begin
            if (serve[c]) begin
                pick_strict = CLS_W'(c);
            end
        end
    end

    // round robin: rotate so bit 0 is the class after the pointer
    always_comb begin
        serve_dbl = {serve, serve};
        serve_rot = NUM_CLASSES'(serve_dbl >> ((CLS_W+1)'(r_rr) + 1'b1));
        rot_off   = '0;
        for (int j = NUM_CLASSES - 1; j >= 0; j--) begin
            if (serve_rot[j]) begin
                rot_off = (CLS_W+1)'(j);
            end
        end
        rr_sum = (CLS_W+1)'(r_rr) + 1'b1 + rot_off;
        if (rr_sum >= (CLS_W+1)'(NUM_CLASSES)) begin
            rr_sum = rr_sum - (CLS_W+1)'(NUM_CLASSES);
        end
        pick_rr = CLS_W'(rr_sum);
    end

    assign found = |serve;
    assign pick  = (r_sched_mode == MODE_RR) ? pick_rr : pick_strict;

    // enqueue admission: class in range, room left, byte limit held
    assign sum_bytes = {1'b0, r_all} + 33'(r_item.packet_length);
    assign enq_ok    = r_cls_ok && (r_count[r_wcls] < CNT_W'(FIFO_DEPTH)) &&
                       (sum_bytes < {1'b0, r_max_bytes});

    // single read place of the byte counts
    assign bytes_idx = i_cmd.result ? CLS_W'(r_item.class_index) : r_wcls;
    assign bytes_rd  = r_bytes[bytes_idx];

    assign o_status.is_deq   = is_deq;
    assign o_status.found    = found;
    assign o_status.out_free = !r_out_valid || !i_out_stall;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_bytes  <= MAX_BYTES_RESET;
            r_sched_mode <= MODE_STRICT;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MAX_BYTES:  r_max_bytes  <= i_cfg_data;
                CFG_SCHED_MODE: r_sched_mode <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // length memory: write on enqueue, registered head read on dequeue
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && !is_deq && enq_ok) begin
            mem[r_wcls][r_tail[r_wcls]] <= r_item.packet_length;
        end
        if (i_cmd.exec && is_deq) begin
            r_rd_data <= mem[pick][r_head[pick]];
        end
    end

    // queue state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < NUM_CLASSES; c++) begin
                r_head[c]  <= '0;
                r_tail[c]  <= '0;
                r_count[c] <= '0;
                r_bytes[c] <= '0;
            end
            r_all <= '0;
            r_rr  <= '0;
        end else begin
            if (i_cmd.exec && !is_deq && enq_ok) begin
                r_tail[r_wcls]  <= ptr_next(r_tail[r_wcls]);
                r_count[r_wcls] <= r_count[r_wcls] + 1'b1;
                r_bytes[r_wcls] <= bytes_rd + 32'(r_item.packet_length);
                r_all           <= sum_bytes[31:0];
            end
            if (i_cmd.exec && is_deq && found) begin
                r_head[pick]  <= ptr_next(r_head[pick]);
                r_count[pick] <= r_count[pick] - 1'b1;
                r_rr          <= pick;
            end
            if (i_cmd.finish) begin
                r_bytes[r_wcls] <= bytes_rd - 32'(r_rd_data);
                r_all           <= r_all - 32'(r_rd_data);
            end
        end
    end

    // item in flight and partial result
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_item   <= i_in_item;
            r_wcls   <= CLS_W'(i_in_item.class_index);
            r_cls_ok <= cls_ok_in;
        end
        if (i_cmd.exec) begin
            r_sent_len <= '0;
            if (is_deq) begin
                r_acc      <= 1'b0;
                r_sent     <= found;
                r_sent_cls <= found ? 3'(pick) : 3'd0;
                r_wcls     <= pick;
            end else begin
                r_acc      <= enq_ok;
                r_sent     <= 1'b0;
                r_sent_cls <= 3'd0;
            end
        end
        if (i_cmd.finish) begin
            r_sent_len <= r_rd_data;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_item.accepted    <= r_acc;
            r_out_item.sent        <= r_sent;
            r_out_item.sent_class  <= r_sent_cls;
            r_out_item.sent_length <= r_sent_len;
            r_out_item.total_bytes <= r_all;
            r_out_item.class_bytes <= r_cls_ok ? bytes_rd : 32'd0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

// ===== sv/egress_class_queue_scheduler.sv =====
// ---------------------------------------------------------------------------
// egress_class_queue_scheduler
// Egress port with one packet length queue per traffic class, byte limit
// admission, and strict priority or round robin dequeue under a pause mask.
// ---------------------------------------------------------------------------
//   channel | handshake                 | payload
//   --------+---------------------------+----------------------------------
//   in      | i_in_valid / o_in_stall   | i_in_item  (op, class, length, mask)
//   out     | o_out_valid / i_out_stall | o_out_item (result of one item)
//   config  | i_cfg_we                  | i_cfg_index, i_cfg_data
//
// One item at a time: an enqueue runs the execute and result states, and a
// dequeue that sends runs the head read too, a registered length memory read.
// The next item is taken in the cycle its predecessor moves to the output
// register. Synchronous active-low reset; no memory clearing pass is needed.
// A stalled output holds its result and the block waits before the next one.
// ---------------------------------------------------------------------------
module egress_class_queue_scheduler
    import ecqs_pkg::*;
#(
    parameter int NUM_CLASSES = 8,
    parameter int FIFO_DEPTH  = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_item,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_ctrl_cmd  cmd;
    t_dp_status status;

    // sequencer
    ecqs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // queues, selection and output stage
    ecqs_dpath #(
        .NUM_CLASSES (NUM_CLASSES),
        .FIFO_DEPTH  (FIFO_DEPTH)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_status    (status)
    );

endmodule

// ===== sv/ecqs_checker.sv =====
// ---------------------------------------------------------------------------
// ecqs_checker
// Port-level checks of the scheduler: one item at a time, consistent result
// fields, and a held output under stall.
// ---------------------------------------------------------------------------
module ecqs_checker
    import ecqs_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_item
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("output item dropped while stalled");

    // an item in work closes the input for the next cycle
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second item taken while one is in work");

    // an item is never both an accepted enqueue and a sent dequeue
    a_acc_sent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_item.accepted && o_out_item.sent))
        else $error("result both accepted and sent");

    // nothing sent reports zero class and length
    a_idle_send: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.sent |->
            (o_out_item.sent_class == 3'd0) && (o_out_item.sent_length == 16'd0))
        else $error("unsent dequeue carries class or length");

    // one class never holds more than the whole port
    a_class_le_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.class_bytes <= o_out_item.total_bytes))
        else $error("class bytes exceed total bytes");

endmodule

bind egress_class_queue_scheduler ecqs_checker u_ecqs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);
